@@ rtl/pfla_pkg.sv @@
`timescale 1ns / 1ps

package pfla_pkg;

	// default sizing of the allocator
	localparam int DEF_TABLES        = 4;
	localparam int DEF_MAX_PAGES     = 4096;
	localparam int DEF_INITIAL_PAGES = 16;

	// growth of a table whose free list has run dry
	localparam int GROWTH_FACTOR = 2;

	// fixed field widths
	localparam int REQ_W    = 2;
	localparam int SEL_W    = 2;
	localparam int PAGE_W   = 12;
	localparam int STATUS_W = 2;

	// stream packing
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = REQ_W;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = STATUS_W;

	localparam int SEL_LSB  = 0;
	localparam int PAGE_LSB = SEL_LSB + SEL_W;
	localparam int ROOT_LSB = PAGE_LSB + PAGE_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC    = 2'd0,
		REQ_FREE     = 2'd1,
		REQ_GET_ROOT = 2'd2,
		REQ_SET_ROOT = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_LOOK,
		S_POP,
		S_GROW
	} fsm_t;

endpackage

@@ rtl/pfla_ram.sv @@
`timescale 1ns / 1ps

module pfla_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pfla_ctrl.sv @@
`timescale 1ns / 1ps

module pfla_ctrl #(
	parameter int TABLES        = pfla_pkg::DEF_TABLES,
	parameter int MAX_PAGES     = pfla_pkg::DEF_MAX_PAGES,
	parameter int INITIAL_PAGES = pfla_pkg::DEF_INITIAL_PAGES,
	parameter int TW            = (TABLES > 1) ? $clog2(TABLES) : 1,
	parameter int PW            = $clog2(MAX_PAGES),
	parameter int CW            = $clog2(MAX_PAGES + 1),
	parameter int EW            = pfla_pkg::PAGE_W + CW + PW,
	parameter int LAW           = $clog2(TABLES * MAX_PAGES)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pfla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic [pfla_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [pfla_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [pfla_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
	// table state memory
	output logic                               tm_we,
	output logic [TW-1:0]                      tm_waddr,
	output logic [EW-1:0]                      tm_wdata,
	output logic                               tm_re,
	output logic [TW-1:0]                      tm_raddr,
	input  logic [EW-1:0]                      tm_rdata,
	// link memory
	output logic                               lm_we,
	output logic [LAW-1:0]                     lm_waddr,
	output logic [PW-1:0]                      lm_wdata,
	output logic                               lm_re,
	output logic [LAW-1:0]                     lm_raddr,
	input  logic [PW-1:0]                      lm_rdata
);

	import pfla_pkg::*;

	localparam int START = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES : INITIAL_PAGES;
	localparam int CMP_W = (CW > PAGE_W) ? CW : PAGE_W;

	function automatic logic [LAW-1:0] link_addr(input logic [TW-1:0] t,
			input logic [PW-1:0] p);
		return LAW'(t) * LAW'(MAX_PAGES) + LAW'(p);
	endfunction

	fsm_t               st_q, st_d;
	req_type_t          req_q;
	logic [TW-1:0]      tsel_q;
	logic [PAGE_W-1:0]  pg_q;
	logic [PAGE_W-1:0]  root_q;
	logic [EW-1:0]      ent_q;
	logic [PW-1:0]      i_q;
	logic [TW-1:0]      ti_q;
	logic [PW-1:0]      pi_q;
	logic               out_valid_q;
	logic [PAGE_W-1:0]  out_page_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [TW-1:0]      tsel_in;
	logic               accept;
	logic               deliver_ok;
	logic               load_out;
	logic [PAGE_W-1:0]  res_page;
	status_t            res_status;
	logic               init_last;

	// fields of the entry just read and of the held entry
	logic [PAGE_W-1:0]  rd_root, ent_root;
	logic [CW-1:0]      rd_cnt, ent_cnt;
	logic [PW-1:0]      rd_head, ent_head;
	logic [CW:0]        rd_grown;
	logic               grow_over;
	logic               bad_free;
	logic [CW-1:0]      ent_grown;
	logic [PW-1:0]      grow_last;
	logic               grow_is_last;

	assign {rd_root, rd_cnt, rd_head}    = tm_rdata;
	assign {ent_root, ent_cnt, ent_head} = ent_q;

	// table select wraps modulo the table count
	always_comb begin
		logic [SEL_W-1:0] v;
		v = s_axis_tdata[SEL_LSB +: SEL_W];
		for (int k = 0; k < 3; k++) begin
			if (32'(v) >= TABLES) begin
				v = v - SEL_W'(TABLES);
			end
		end
		tsel_in = TW'(v);
	end

	assign rd_grown     = {rd_cnt, 1'b0};
	assign grow_over    = rd_grown > (CW+1)'(MAX_PAGES);
	assign bad_free     = (pg_q == '0) || (CMP_W'(pg_q) >= CMP_W'(rd_cnt));
	assign ent_grown    = CW'({ent_cnt, 1'b0});
	assign grow_last    = PW'(ent_grown - CW'(1));
	assign grow_is_last = (i_q == grow_last);
	assign init_last    = (ti_q == TW'(TABLES - 1)) && (pi_q == PW'(START - 1));

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign deliver_ok = !out_valid_q || m_axis_tready;

	always_comb begin
		st_d          = st_q;
		s_axis_tready = 1'b0;
		tm_we         = 1'b0;
		tm_waddr      = tsel_q;
		tm_wdata      = ent_q;
		tm_re         = 1'b0;
		tm_raddr      = tsel_in;
		lm_we         = 1'b0;
		lm_waddr      = link_addr(tsel_q, i_q);
		lm_wdata      = '0;
		lm_re         = 1'b0;
		lm_raddr      = link_addr(tsel_q, rd_head);
		load_out      = 1'b0;
		res_page      = '0;
		res_status    = STAT_OK;

		case (st_q)
			S_INIT: begin
				// chain the initial pages of every table, header entry alongside
				tm_we    = (pi_q == PW'(1));
				tm_waddr = ti_q;
				tm_wdata = {PAGE_W'(0), CW'(START), PW'(START - 1)};
				lm_we    = 1'b1;
				lm_waddr = link_addr(ti_q, pi_q);
				lm_wdata = pi_q - PW'(1);
				if (init_last) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					tm_re = 1'b1;
					st_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				case (req_q)
					REQ_ALLOC: begin
						if (rd_head != '0) begin
							lm_re = 1'b1;
							st_d  = S_POP;
						end else if (!grow_over) begin
							st_d = S_GROW;
						end else if (deliver_ok) begin
							load_out   = 1'b1;
							res_status = STAT_FULL;
							st_d       = S_IDLE;
						end
					end
					REQ_FREE: begin
						if (deliver_ok) begin
							load_out = 1'b1;
							st_d     = S_IDLE;
							if (bad_free) begin
								res_status = STAT_BAD_FREE;
							end else begin
								lm_we    = 1'b1;
								lm_waddr = link_addr(tsel_q, PW'(pg_q));
								lm_wdata = rd_head;
								tm_we    = 1'b1;
								tm_wdata = {rd_root, rd_cnt, PW'(pg_q)};
							end
						end
					end
					REQ_GET_ROOT: begin
						if (deliver_ok) begin
							load_out = 1'b1;
							res_page = rd_root;
							st_d     = S_IDLE;
						end
					end
					REQ_SET_ROOT: begin
						if (deliver_ok) begin
							load_out = 1'b1;
							tm_we    = 1'b1;
							tm_wdata = {root_q, rd_cnt, rd_head};
							st_d     = S_IDLE;
						end
					end
					default: begin
						st_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				if (deliver_ok) begin
					load_out = 1'b1;
					res_page = PAGE_W'(ent_head);
					tm_we    = 1'b1;
					tm_wdata = {ent_root, ent_cnt, lm_rdata};
					st_d     = S_IDLE;
				end
			end
			S_GROW: begin
				// first new page ends the list, the rest point one below
				lm_wdata = (i_q == PW'(ent_cnt)) ? '0 : i_q - PW'(1);
				if (!grow_is_last) begin
					lm_we = 1'b1;
				end else if (deliver_ok) begin
					// the top page is handed out straight away, its link is known
					lm_we    = 1'b1;
					tm_we    = 1'b1;
					tm_wdata = {ent_root, ent_grown, grow_last - PW'(1)};
					load_out = 1'b1;
					res_page = PAGE_W'(grow_last);
					st_d     = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q <= '0;
			pi_q <= PW'(1);
		end else if (st_q == S_INIT) begin
			if (pi_q == PW'(START - 1)) begin
				pi_q <= PW'(1);
				ti_q <= ti_q + TW'(1);
			end else begin
				pi_q <= pi_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type_t'(s_axis_tuser);
			tsel_q <= tsel_in;
			pg_q   <= s_axis_tdata[PAGE_LSB +: PAGE_W];
			root_q <= s_axis_tdata[ROOT_LSB +: PAGE_W];
		end
		if (st_q == S_LOOK) begin
			ent_q <= tm_rdata;
			i_q   <= PW'(rd_cnt);
		end else if (st_q == S_GROW && lm_we && !grow_is_last) begin
			i_q <= i_q + PW'(1);
		end
		if (load_out) begin
			out_page_q   <= res_page;
			out_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - PAGE_W){1'b0}}, out_page_q};
	assign m_axis_tuser  = out_status_q;

endmodule

@@ rtl/page_free_list_allocator_unit.sv @@
`timescale 1ns / 1ps

// channel   | dir | tdata (lsb up)                          | tuser
// s_axis    | in  | table_sel[1:0] page_in[13:2] root_in[25:14] | req_type[1:0]
// m_axis    | out | page_out[11:0]                          | status[1:0]
//
// allocate from a non-empty list: accept, header read, link read
// free, get root, set root, table full: accept, header read
// allocate that doubles the table: accept, header read, then one link memory write
// per new page, n new pages with n the page count before growth
// after reset the initial chains are written,
// while tready stays low
// a result waits in the output register; the next request is taken meanwhile and
// holds in its last step until that register frees

module page_free_list_allocator_unit #(
	parameter int TABLES        = pfla_pkg::DEF_TABLES,
	parameter int MAX_PAGES     = pfla_pkg::DEF_MAX_PAGES,
	parameter int INITIAL_PAGES = pfla_pkg::DEF_INITIAL_PAGES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// table_sel, page_in, root_in
	input  logic [pfla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [pfla_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// page_out
	output logic [pfla_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// status
	output logic [pfla_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	import pfla_pkg::*;

	localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int PW    = $clog2(MAX_PAGES);
	localparam int CW    = $clog2(MAX_PAGES + 1);
	localparam int EW    = PAGE_W + CW + PW;
	localparam int LDEP  = TABLES * MAX_PAGES;
	localparam int LAW   = $clog2(LDEP);

	logic           tm_we, tm_re;
	logic [TW-1:0]  tm_waddr, tm_raddr;
	logic [EW-1:0]  tm_wdata, tm_rdata;
	logic           lm_we, lm_re;
	logic [LAW-1:0] lm_waddr, lm_raddr;
	logic [PW-1:0]  lm_wdata, lm_rdata;

	pfla_ctrl #(
		.TABLES        (TABLES),
		.MAX_PAGES     (MAX_PAGES),
		.INITIAL_PAGES (INITIAL_PAGES),
		.TW            (TW),
		.PW            (PW),
		.CW            (CW),
		.EW            (EW),
		.LAW           (LAW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.tm_we         (tm_we),
		.tm_waddr      (tm_waddr),
		.tm_wdata      (tm_wdata),
		.tm_re         (tm_re),
		.tm_raddr      (tm_raddr),
		.tm_rdata      (tm_rdata),
		.lm_we         (lm_we),
		.lm_waddr      (lm_waddr),
		.lm_wdata      (lm_wdata),
		.lm_re         (lm_re),
		.lm_raddr      (lm_raddr),
		.lm_rdata      (lm_rdata)
	);

	// per-table header: root, page count, free head
	pfla_ram #(
		.DW    (EW),
		.DEPTH (TABLES),
		.AW    (TW)
	) u_tbl_mem (
		.clk   (clk),
		.we    (tm_we),
		.waddr (tm_waddr),
		.wdata (tm_wdata),
		.re    (tm_re),
		.raddr (tm_raddr),
		.rdata (tm_rdata)
	);

	// successor links of all tables
	pfla_ram #(
		.DW    (PW),
		.DEPTH (LDEP),
		.AW    (LAW)
	) u_link_mem (
		.clk   (clk),
		.we    (lm_we),
		.waddr (lm_waddr),
		.wdata (lm_wdata),
		.re    (lm_re),
		.raddr (lm_raddr),
		.rdata (lm_rdata)
	);

	// one request in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in progress");

	// link memory is never read and written in the same cycle
	a_link_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(lm_we && lm_re))
		else $error("link memory read and write collide");

	// link writes stay inside the array
	a_link_range: assert property (@(posedge clk) disable iff (!arst_n)
		lm_we |-> (32'(lm_waddr) < LDEP))
		else $error("link write address out of range");

	// a header read is issued only for an accepted request
	a_hdr_read: assert property (@(posedge clk) disable iff (!arst_n)
		tm_re |-> (s_axis_tvalid && s_axis_tready && !tm_we))
		else $error("header read without a transfer");

endmodule
